/* hdl/fbt_pkg.sv */
// Shared types, constants and the 6x8 font table for the page frame buffer text engine.
// Depends on nothing; fbt_front, fbt_back, the top level and the testbench import it.
`default_nettype none
package fbt_pkg;

    localparam int DEF_DISP_W = 100;
    localparam int DEF_DISP_H = 64;
    localparam int GLYPH_W    = 6;
    localparam int GLYPH_H    = 8;

    // Command codes on the input stream.
    localparam logic [3:0] FN_SET   = 4'd0;
    localparam logic [3:0] FN_CLR   = 4'd1;
    localparam logic [3:0] FN_HLINE = 4'd2;
    localparam logic [3:0] FN_VLINE = 4'd3;
    localparam logic [3:0] FN_GLYPH = 4'd4;
    localparam logic [3:0] FN_CURS  = 4'd5;
    localparam logic [3:0] FN_PUTC  = 4'd6;
    localparam logic [3:0] FN_ERASE = 4'd7;
    localparam logic [3:0] FN_READ  = 4'd8;

    // Work kinds handed from the front to the back.
    typedef enum logic [2:0] {
        K_NOP   = 3'd0,
        K_PIX   = 3'd1,
        K_HLINE = 3'd2,
        K_VLINE = 3'd3,
        K_GLYPH = 3'd4,
        K_ERASE = 3'd5,
        K_READ  = 3'd6
    } fbt_kind_t;

    typedef struct packed {
        fbt_kind_t   kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [6:0]  code;
        logic        pix_on;
        logic        drawn;
    } fbt_cmd_t;

    // Column c of glyph code: byte c sits at bits [47-8c -: 8].
    function automatic logic [7:0] fbt_font_col(input logic [6:0] code, input logic [2:0] c);
        logic [47:0] g;
        case (code)
            7'd33:  g = 48'h00065F060000;
            7'd34:  g = 48'h070300070300;
            7'd35:  g = 48'h247E247E2400;
            7'd36:  g = 48'h242B6A120000;
            7'd37:  g = 48'h631308646300;
            7'd38:  g = 48'h304C52225000;
            7'd39:  g = 48'h000703000000;
            7'd40:  g = 48'h003E41000000;
            7'd41:  g = 48'h00413E000000;
            7'd42:  g = 48'h083E1C3E0800;
            7'd43:  g = 48'h08083E080800;
            7'd44:  g = 48'h806060000000;
            7'd45:  g = 48'h080808080800;
            7'd46:  g = 48'h006060000000;
            7'd47:  g = 48'h201008040200;
            7'd48:  g = 48'h3E5149453E00;
            7'd49:  g = 48'h00427F400000;
            7'd50:  g = 48'h625149494600;
            7'd51:  g = 48'h224949493600;
            7'd52:  g = 48'h1814127F1000;
            7'd53:  g = 48'h2F4949493100;
            7'd54:  g = 48'h3C4A49493000;
            7'd55:  g = 48'h017109050300;
            7'd56:  g = 48'h364949493600;
            7'd57:  g = 48'h064949291E00;
            7'd58:  g = 48'h006C6C000000;
            7'd59:  g = 48'h00EC6C000000;
            7'd60:  g = 48'h081422410000;
            7'd61:  g = 48'h242424242400;
            7'd62:  g = 48'h004122140800;
            7'd63:  g = 48'h020159090600;
            7'd64:  g = 48'h3E415D551E00;
            7'd65:  g = 48'h7E1111117E00;
            7'd66:  g = 48'h7F4949493600;
            7'd67:  g = 48'h3E4141412200;
            7'd68:  g = 48'h7F4141413E00;
            7'd69:  g = 48'h7F4949494100;
            7'd70:  g = 48'h7F0909090100;
            7'd71:  g = 48'h3E4149497A00;
            7'd72:  g = 48'h7F0808087F00;
            7'd73:  g = 48'h00417F410000;
            7'd74:  g = 48'h304040403F00;
            7'd75:  g = 48'h7F0814224100;
            7'd76:  g = 48'h7F4040404000;
            7'd77:  g = 48'h7F0204027F00;
            7'd78:  g = 48'h7F0204087F00;
            7'd79:  g = 48'h3E4141413E00;
            7'd80:  g = 48'h7F0909090600;
            7'd81:  g = 48'h3E4151215E00;
            7'd82:  g = 48'h7F0909196600;
            7'd83:  g = 48'h264949493200;
            7'd84:  g = 48'h01017F010100;
            7'd85:  g = 48'h3F4040403F00;
            7'd86:  g = 48'h1F2040201F00;
            7'd87:  g = 48'h3F403C403F00;
            7'd88:  g = 48'h631408146300;
            7'd89:  g = 48'h070870080700;
            7'd90:  g = 48'h714945430000;
            7'd91:  g = 48'h007F41410000;
            7'd92:  g = 48'h020408102000;
            7'd93:  g = 48'h0041417F0000;
            7'd94:  g = 48'h040201020400;
            7'd95:  g = 48'h808080808000;
            7'd96:  g = 48'h000205020000;
            7'd97:  g = 48'h205454547800;
            7'd98:  g = 48'h7F4444443800;
            7'd99:  g = 48'h384444442800;
            7'd100: g = 48'h384444447F00;
            7'd101: g = 48'h385454540800;
            7'd102: g = 48'h087E09090000;
            7'd103: g = 48'h1824A4A4FC00;
            7'd104: g = 48'h7F0404780000;
            7'd105: g = 48'h00007D400000;
            7'd106: g = 48'h4080847D0000;
            7'd107: g = 48'h7F1028440000;
            7'd108: g = 48'h00007F400000;
            7'd109: g = 48'h7C0418047800;
            7'd110: g = 48'h7C0404780000;
            7'd111: g = 48'h384444443800;
            7'd112: g = 48'hFC4444443800;
            7'd113: g = 48'h38444444FC00;
            7'd114: g = 48'h447844040800;
            7'd115: g = 48'h085454542000;
            7'd116: g = 48'h043E44240000;
            7'd117: g = 48'h3C40207C0000;
            7'd118: g = 48'h1C2040201C00;
            7'd119: g = 48'h3C6030603C00;
            7'd120: g = 48'h6C10106C0000;
            7'd121: g = 48'h9CA0603C0000;
            7'd122: g = 48'h6454544C0000;
            7'd123: g = 48'h083E41410000;
            7'd124: g = 48'h000077000000;
            7'd125: g = 48'h0041413E0800;
            7'd126: g = 48'h020102010000;
            7'd127: g = 48'h102040380700;
            default: g = 48'h0;
        endcase
        case (c)
            3'd0:    fbt_font_col = g[47:40];
            3'd1:    fbt_font_col = g[39:32];
            3'd2:    fbt_font_col = g[31:24];
            3'd3:    fbt_font_col = g[23:16];
            3'd4:    fbt_font_col = g[15:8];
            3'd5:    fbt_font_col = g[7:0];
            default: fbt_font_col = 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

/* hdl/fbt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the frame store.
`default_nettype none
module fbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 800
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* hdl/fbt_front.sv */
// Front part: accepts input items, tracks the text cursor, classifies each item
// into a work command and queues it for the back part. Depends on fbt_pkg.
`default_nettype none
module fbt_front #(
    parameter int DISP_W = fbt_pkg::DEF_DISP_W,
    parameter int DISP_H = fbt_pkg::DEF_DISP_H
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [47:0]      s_tdata,
    input  wire logic             hold,
    output logic                  q_valid,
    output fbt_pkg::fbt_cmd_t     q_cmd,
    input  wire logic             q_pop
);
    import fbt_pkg::*;

    logic [3:0] func;
    logic [7:0] in_x, in_y, in_xe, in_ye;
    logic [6:0] in_code;
    assign func    = s_tdata[3:0];
    assign in_x    = s_tdata[11:4];
    assign in_y    = s_tdata[19:12];
    assign in_xe   = s_tdata[27:20];
    assign in_ye   = s_tdata[35:28];
    assign in_code = s_tdata[42:36];

    fbt_cmd_t   q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [7:0] ccol_reg, crow_reg;
    logic [7:0] ccol_next, crow_next;
    fbt_cmd_t   cmd;
    logic       accept;

    // Put-char wrap and drop decision.
    logic       wrap, drawable;
    logic [8:0] nr;
    logic [7:0] pc_col, pc_row;

    assign s_tready = (cnt_reg != 2'd2) && !hold;
    assign accept   = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wrap     = {1'b0, ccol_reg} > 9'(DISP_W - GLYPH_W);
        nr       = {1'b0, crow_reg} + 9'(GLYPH_H);
        pc_col   = wrap ? 8'd0 : ccol_reg;
        pc_row   = wrap ? ((nr > 9'(DISP_H - GLYPH_H)) ? 8'd0 : nr[7:0]) : crow_reg;
        drawable = {1'b0, pc_row} <= 9'(DISP_H - GLYPH_H);

        ccol_next = ccol_reg;
        crow_next = crow_reg;

        cmd        = '0;
        cmd.kind   = K_NOP;
        cmd.col    = in_x;
        cmd.row    = in_y;
        cmd.code   = in_code;
        cmd.lo     = 8'd0;
        cmd.hi     = 8'd0;
        case (func)
            FN_SET:
            begin
                cmd.kind   = K_PIX;
                cmd.pix_on = 1'b1;
            end
            FN_CLR:
            begin
                cmd.kind = K_PIX;
            end
            FN_HLINE:
            begin
                cmd.kind = K_HLINE;
                cmd.lo   = (in_x < in_xe) ? in_x : in_xe;
                cmd.hi   = (in_x < in_xe) ? in_xe : in_x;
            end
            FN_VLINE:
            begin
                cmd.kind = K_VLINE;
                cmd.lo   = (in_y < in_ye) ? in_y : in_ye;
                cmd.hi   = (in_y < in_ye) ? in_ye : in_y;
            end
            FN_GLYPH:
            begin
                cmd.kind = K_GLYPH;
            end
            FN_CURS:
            begin
                ccol_next = in_x;
                crow_next = in_y;
            end
            FN_PUTC:
            begin
                ccol_next = pc_col;
                crow_next = pc_row;
                if (drawable)
                begin
                    cmd.kind  = K_GLYPH;
                    cmd.col   = pc_col;
                    cmd.row   = pc_row;
                    cmd.drawn = 1'b1;
                    ccol_next = pc_col + 8'(GLYPH_W);
                end
            end
            FN_ERASE:
            begin
                cmd.kind = K_ERASE;
            end
            FN_READ:
            begin
                cmd.kind = K_READ;
            end
            default:
            begin
                cmd.kind = K_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            ccol_reg   <= 8'd0;
            crow_reg   <= 8'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
                ccol_reg   <= ccol_next;
                crow_reg   <= crow_next;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(accept) - 2'(q_pop && q_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end
endmodule
`default_nettype wire

/* hdl/fbt_back.sv */
// Back part: carries out queued commands as read-modify-write steps on the
// frame store, runs clearing sweeps and holds the result register. Depends on fbt_pkg, fbt_ram.
`default_nettype none
module fbt_back #(
    parameter int DISP_W = fbt_pkg::DEF_DISP_W,
    parameter int DISP_H = fbt_pkg::DEF_DISP_H
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  fbt_pkg::fbt_cmd_t     q_cmd,
    output logic                  q_pop,
    output logic                  hold,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [15:0]           m_tdata
);
    import fbt_pkg::*;

    localparam int NUM_PAGES = (DISP_H + 7) / 8;
    localparam int STORE     = NUM_PAGES * DISP_W;
    localparam int AW        = $clog2(STORE);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_WR   = 5'b00100,
        S_DONE = 5'b01000,
        S_CLR  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    fbt_cmd_t    cmd_reg;
    logic [7:0]  cur_reg, end_reg;
    logic [AW-1:0] addr_reg, clr_reg;
    logic [7:0]  mask_reg, data_reg, rdat_reg;
    logic        init_reg;
    logic        out_valid_reg;
    logic [7:0]  out_rd_reg;
    logic        out_drawn_reg;

    logic [8:0]  step_col;
    logic [5:0]  step_page;
    logic [7:0]  step_mask, step_data, rowv;
    logic        step_ok;
    logic [AW-1:0] step_addr;
    logic [7:0]  font_byte;
    logic [15:0] sft_data, sft_mask;
    logic [7:0]  lo_m, hi_m;
    logic [7:0]  ram_q;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]  ram_wdata;
    logic        last_step;

    assign hold     = init_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_drawn_reg, out_rd_reg};
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign last_step = (cur_reg == end_reg);

    // Byte selected by the current step of the command.
    always_comb
    begin
        font_byte = fbt_font_col(cmd_reg.code, cur_reg[3:1]);
        sft_data  = {8'd0, font_byte} << cmd_reg.row[2:0];
        sft_mask  = 16'h00FF << cmd_reg.row[2:0];
        lo_m      = 8'hFF;
        hi_m      = 8'hFF;
        step_col  = {1'b0, cmd_reg.col};
        step_page = {1'b0, cmd_reg.row[7:3]};
        step_mask = 8'h01 << cmd_reg.row[2:0];
        step_data = 8'hFF;
        case (cmd_reg.kind)
            K_PIX:
            begin
                step_data = cmd_reg.pix_on ? 8'hFF : 8'h00;
            end
            K_HLINE:
            begin
                step_col = {1'b0, cur_reg};
            end
            K_VLINE:
            begin
                step_page = cur_reg[5:0];
                if (cur_reg[4:0] == cmd_reg.lo[7:3])
                begin
                    lo_m = 8'hFF << cmd_reg.lo[2:0];
                end
                if (cur_reg[4:0] == cmd_reg.hi[7:3])
                begin
                    hi_m = 8'hFF >> (~cmd_reg.hi[2:0]);
                end
                step_mask = lo_m & hi_m;
            end
            K_GLYPH:
            begin
                step_col  = {1'b0, cmd_reg.col} + {6'd0, cur_reg[3:1]};
                step_page = {1'b0, cmd_reg.row[7:3]} + {5'd0, cur_reg[0]};
                step_data = cur_reg[0] ? sft_data[15:8] : sft_data[7:0];
                step_mask = cur_reg[0] ? sft_mask[15:8] : sft_mask[7:0];
            end
            default:
            begin
                step_mask = 8'hFF;
            end
        endcase
        for (int r = 0; r < 8; r++)
        begin
            rowv[r] = ({step_page, 3'b000} + 9'(r)) < 9'(DISP_H);
        end
        if (cmd_reg.kind == K_READ)
        begin
            step_ok = (step_col < 9'(DISP_W)) && (step_page < 6'(NUM_PAGES));
        end
        else
        begin
            step_ok = (step_col < 9'(DISP_W)) && (step_page < 6'(NUM_PAGES))
                      && ((step_mask & rowv) != 8'h00);
        end
        step_addr = AW'(step_page) * AW'(DISP_W) + AW'(step_col);
    end

    always_comb
    begin
        ram_re    = (state_reg == S_STEP) && step_ok;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = (ram_q & ~mask_reg) | (data_reg & mask_reg);
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 8'h00;
        end
        else if ((state_reg == S_WR) && (cmd_reg.kind != K_READ))
        begin
            ram_we = 1'b1;
        end
    end

    fbt_ram #(
        .WIDTH (8),
        .DEPTH (STORE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (step_addr),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        K_NOP:   state_next = S_DONE;
                        K_ERASE: state_next = S_CLR;
                        default: state_next = S_STEP;
                    endcase
                end
            end
            S_STEP:
            begin
                if (step_ok)
                begin
                    state_next = S_WR;
                end
                else if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_WR:
            begin
                state_next = last_step ? S_DONE : S_STEP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                if (clr_reg == AW'(STORE - 1))
                begin
                    state_next = init_reg ? S_IDLE : S_DONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cur_reg       <= 8'd0;
            end_reg       <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    clr_reg <= '0;
                    case (q_cmd.kind)
                        K_HLINE:
                        begin
                            cur_reg <= q_cmd.lo;
                            end_reg <= q_cmd.hi;
                        end
                        K_VLINE:
                        begin
                            cur_reg <= {3'd0, q_cmd.lo[7:3]};
                            end_reg <= {3'd0, q_cmd.hi[7:3]};
                        end
                        K_GLYPH:
                        begin
                            cur_reg <= 8'd0;
                            end_reg <= 8'(2 * GLYPH_W - 1);
                        end
                        default:
                        begin
                            cur_reg <= 8'd0;
                            end_reg <= 8'd0;
                        end
                    endcase
                end
                S_STEP:
                begin
                    if (!step_ok && !last_step)
                    begin
                        cur_reg <= cur_reg + 8'd1;
                    end
                end
                S_WR:
                begin
                    if (!last_step)
                    begin
                        cur_reg <= cur_reg + 8'd1;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(STORE - 1))
                    begin
                        init_reg <= 1'b0;
                    end
                end
                default:
                begin
                    cur_reg <= cur_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= q_cmd;
                rdat_reg <= 8'd0;
            end
            S_STEP:
            begin
                addr_reg <= step_addr;
                mask_reg <= step_mask & rowv;
                data_reg <= step_data;
            end
            S_WR:
            begin
                if (cmd_reg.kind == K_READ)
                begin
                    rdat_reg <= ram_q;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_rd_reg    <= rdat_reg;
                    out_drawn_reg <= cmd_reg.drawn;
                end
            end
            S_CLR:
            begin
                rdat_reg <= 8'd0;
                cmd_reg.drawn <= 1'b0;
            end
            default:
            begin
                rdat_reg <= rdat_reg;
            end
        endcase
    end
endmodule
`default_nettype wire

/* hdl/page_framebuffer_text_engine.sv */
// Flow: with the back part idle, an item is taken from the queue in S_IDLE; each frame byte
// is read in S_STEP and written back (for a read, captured) in S_WR, a step off the display
// passes S_STEP alone, and S_DONE registers the result; an erase sweeps S_CLR over the store.
// Throughput: one item at a time in the back part, bound by the single frame store
// read-modify-write port; a two-entry queue lets the input run ahead.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all ceil(DISP_H/8)*DISP_W
// frame store bytes (800 by default), during which no item is accepted.
`default_nettype none
module page_framebuffer_text_engine #(
    parameter int DISP_W = fbt_pkg::DEF_DISP_W,
    parameter int DISP_H = fbt_pkg::DEF_DISP_H
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // func[3:0] x[11:4] y[19:12] x_end[27:20] y_end[35:28] char_code[42:36]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // read_data[7:0] char_drawn[8]
);
    import fbt_pkg::*;

    fbt_cmd_t q_cmd;
    logic     q_valid, q_pop, hold;

    fbt_front #(
        .DISP_W (DISP_W),
        .DISP_H (DISP_H)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .hold     (hold),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    fbt_back #(
        .DISP_W (DISP_W),
        .DISP_H (DISP_H)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .hold     (hold),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire

/* hdl/fbt_checker.sv */
// Port-level checks for the page frame buffer text engine, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module fbt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[8] && (m_tdata[7:0] != 8'h00)))
        else $error("read data and drawn flag both set");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:9] == 7'd0))
        else $error("padding bits of result not zero");

    a_known_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("input item accepted with unknown data");
endmodule

bind page_framebuffer_text_engine fbt_checker u_fbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* tb/sv/tb_page_framebuffer_text_engine.sv */
// Self-checking testbench for the page frame buffer text engine: drives commands on the
// input stream, predicts every result with a behavioral frame store and compares them.
// Depends on fbt_pkg (command codes, glyph and default display sizes) and the page_framebuffer_text_engine RTL.
module tb_page_framebuffer_text_engine;
    import fbt_pkg::*;

    localparam int W     = DEF_DISP_W;
    localparam int H     = DEF_DISP_H;
    localparam int PAGES = (H + 7) / 8;
    localparam int N_RANDOM = 630;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic [6:0] char_code;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       char_drawn;
    } res_t;

    // Directed row: the fixed result is only used when check_fixed is set.
    typedef struct {
        cmd_t cmd;
        bit   check_fixed;
        res_t fixed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    page_framebuffer_text_engine dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state.
    logic [7:0] shadow_frame [PAGES*W];
    logic [7:0] shadow_col;
    logic [7:0] shadow_row;

    res_t pending_results [$];
    int   error_count;
    int   items_sent;
    int   results_seen;
    int   reads_nonzero;
    int   chars_drawn;
    bit   quiet_tail;
    bit   stall_enable;

    // Font columns, byte 0 is the leftmost column; kept apart from the RTL lookup.
    function automatic logic [7:0] glyph_column(input logic [6:0] code, input int c);
        logic [47:0] g;
        case (code)
            33: g = 48'h00065F060000;  34: g = 48'h070300070300;  35: g = 48'h247E247E2400;
            36: g = 48'h242B6A120000;  37: g = 48'h631308646300;  38: g = 48'h304C52225000;
            39: g = 48'h000703000000;  40: g = 48'h003E41000000;  41: g = 48'h00413E000000;
            42: g = 48'h083E1C3E0800;  43: g = 48'h08083E080800;  44: g = 48'h806060000000;
            45: g = 48'h080808080800;  46: g = 48'h006060000000;  47: g = 48'h201008040200;
            48: g = 48'h3E5149453E00;  49: g = 48'h00427F400000;  50: g = 48'h625149494600;
            51: g = 48'h224949493600;  52: g = 48'h1814127F1000;  53: g = 48'h2F4949493100;
            54: g = 48'h3C4A49493000;  55: g = 48'h017109050300;  56: g = 48'h364949493600;
            57: g = 48'h064949291E00;  58: g = 48'h006C6C000000;  59: g = 48'h00EC6C000000;
            60: g = 48'h081422410000;  61: g = 48'h242424242400;  62: g = 48'h004122140800;
            63: g = 48'h020159090600;  64: g = 48'h3E415D551E00;  65: g = 48'h7E1111117E00;
            66: g = 48'h7F4949493600;  67: g = 48'h3E4141412200;  68: g = 48'h7F4141413E00;
            69: g = 48'h7F4949494100;  70: g = 48'h7F0909090100;  71: g = 48'h3E4149497A00;
            72: g = 48'h7F0808087F00;  73: g = 48'h00417F410000;  74: g = 48'h304040403F00;
            75: g = 48'h7F0814224100;  76: g = 48'h7F4040404000;  77: g = 48'h7F0204027F00;
            78: g = 48'h7F0204087F00;  79: g = 48'h3E4141413E00;  80: g = 48'h7F0909090600;
            81: g = 48'h3E4151215E00;  82: g = 48'h7F0909196600;  83: g = 48'h264949493200;
            84: g = 48'h01017F010100;  85: g = 48'h3F4040403F00;  86: g = 48'h1F2040201F00;
            87: g = 48'h3F403C403F00;  88: g = 48'h631408146300;  89: g = 48'h070870080700;
            90: g = 48'h714945430000;  91: g = 48'h007F41410000;  92: g = 48'h020408102000;
            93: g = 48'h0041417F0000;  94: g = 48'h040201020400;  95: g = 48'h808080808000;
            96: g = 48'h000205020000;  97: g = 48'h205454547800;  98: g = 48'h7F4444443800;
            99: g = 48'h384444442800; 100: g = 48'h384444447F00; 101: g = 48'h385454540800;
            102: g = 48'h087E09090000; 103: g = 48'h1824A4A4FC00; 104: g = 48'h7F0404780000;
            105: g = 48'h00007D400000; 106: g = 48'h4080847D0000; 107: g = 48'h7F1028440000;
            108: g = 48'h00007F400000; 109: g = 48'h7C0418047800; 110: g = 48'h7C0404780000;
            111: g = 48'h384444443800; 112: g = 48'hFC4444443800; 113: g = 48'h38444444FC00;
            114: g = 48'h447844040800; 115: g = 48'h085454542000; 116: g = 48'h043E44240000;
            117: g = 48'h3C40207C0000; 118: g = 48'h1C2040201C00; 119: g = 48'h3C6030603C00;
            120: g = 48'h6C10106C0000; 121: g = 48'h9CA0603C0000; 122: g = 48'h6454544C0000;
            123: g = 48'h083E41410000; 124: g = 48'h000077000000; 125: g = 48'h0041413E0800;
            126: g = 48'h020102010000; 127: g = 48'h102040380700;
            default: g = 48'h0;
        endcase
        return g[47 - 8*c -: 8];
    endfunction

    function automatic void plot(input int px, input int py, input bit on);
        if (px < W && py < H) begin
            shadow_frame[(py/8)*W + px][py%8] = on;
        end
    endfunction

    function automatic void blit_glyph(input int gx, input int gy, input logic [6:0] code);
        logic [7:0] bits;
        for (int c = 0; c < GLYPH_W; c++) begin
            bits = glyph_column(code, c);
            for (int r = 0; r < GLYPH_H; r++) begin
                plot(gx + c, gy + r, bits[r]);
            end
        end
    endfunction

    // Applies one command to the shadow frame and returns the result it should produce.
    function automatic res_t apply_command(input cmd_t cmd);
        res_t res;
        int lo;
        int hi;
        int next_row;
        res = '0;
        case (cmd.func)
            FN_SET: plot(cmd.x, cmd.y, 1'b1);
            FN_CLR: plot(cmd.x, cmd.y, 1'b0);
            FN_HLINE:
            begin
                lo = (cmd.x < cmd.x_end) ? cmd.x : cmd.x_end;
                hi = (cmd.x < cmd.x_end) ? cmd.x_end : cmd.x;
                for (int i = lo; i <= hi; i++) plot(i, cmd.y, 1'b1);
            end
            FN_VLINE:
            begin
                lo = (cmd.y < cmd.y_end) ? cmd.y : cmd.y_end;
                hi = (cmd.y < cmd.y_end) ? cmd.y_end : cmd.y;
                for (int i = lo; i <= hi; i++) plot(cmd.x, i, 1'b1);
            end
            FN_GLYPH: blit_glyph(cmd.x, cmd.y, cmd.char_code);
            FN_CURS:
            begin
                shadow_col = cmd.x;
                shadow_row = cmd.y;
            end
            FN_PUTC:
            begin
                if (shadow_col > W - GLYPH_W) begin
                    next_row   = shadow_row + GLYPH_H;
                    shadow_col = 0;
                    shadow_row = (next_row > H - GLYPH_H) ? 8'd0 : 8'(next_row);
                end
                if (shadow_row <= H - GLYPH_H) begin
                    blit_glyph(shadow_col, shadow_row, cmd.char_code);
                    shadow_col     = 8'(shadow_col + GLYPH_W);
                    res.char_drawn = 1'b1;
                end
            end
            FN_ERASE: foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
            FN_READ:
            begin
                if (cmd.x < W && (cmd.y / 8) < PAGES) begin
                    res.read_data = shadow_frame[(cmd.y/8)*W + cmd.x];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [47:0] pack_cmd(input cmd_t cmd);
        return {5'b0, cmd.char_code, cmd.y_end, cmd.x_end, cmd.y, cmd.x, cmd.func};
    endfunction

    function automatic cmd_t make_cmd(input logic [3:0] f, input int x, input int y,
                                      input int xe, input int ye, input int code);
        cmd_t c;
        c.func = f; c.x = 8'(x); c.y = 8'(y); c.x_end = 8'(xe); c.y_end = 8'(ye);
        c.char_code = 7'(code);
        return c;
    endfunction

    // Coordinates mostly on or near the display, sometimes anywhere in the field.
    function automatic logic [7:0] pick_coord(input int span);
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, span + 8));
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int pick;
        c = make_cmd(4'd0, 0, 0, 0, 0, 0);
        c.char_code = 7'($urandom_range(0, 127));
        c.x_end     = pick_coord(W);
        c.y_end     = pick_coord(H);
        c.x         = pick_coord(W);
        c.y         = pick_coord(H);
        pick = $urandom_range(0, 99);
        if (pick < 12)      c.func = FN_SET;
        else if (pick < 18) c.func = FN_CLR;
        else if (pick < 26) c.func = FN_HLINE;
        else if (pick < 34) c.func = FN_VLINE;
        else if (pick < 44) c.func = FN_GLYPH;
        else if (pick < 49) c.func = FN_CURS;
        else if (pick < 67) c.func = FN_PUTC;
        else if (pick < 69) c.func = FN_ERASE;
        else if (pick < 97) c.func = FN_READ;
        else                c.func = 4'($urandom_range(9, 15));
        return c;
    endfunction

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sends one item, with a random idle burst ahead of it unless idling is off.
    task automatic send_item(input cmd_t cmd, input bit check_fixed, input res_t fixed);
        res_t predicted;
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_cmd(cmd);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = apply_command(cmd);
        if (check_fixed && predicted != fixed) begin
            $error("directed row func %0d: predicted %h, table says %h",
                   cmd.func, predicted, fixed);
            error_count++;
        end
        pending_results.push_back(check_fixed ? fixed : predicted);
        items_sent++;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Receiver side: random stall bursts while stalls are enabled and the quiet tail has not begun.
    initial
    begin
        int burst;
        m_tready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (burst > 0) begin
                burst--;
                if (burst == 0) m_tready <= 1'b1;
            end else if (stall_enable && !quiet_tail && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8);
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.read_data  = m_tdata[7:0];
            got.char_drawn = m_tdata[8];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result %h arrived with nothing expected", got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.read_data != want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                    error_count++;
                end
                if (got.char_drawn != want.char_drawn) begin
                    $error("char_drawn: expected %0d, got %0d", want.char_drawn, got.char_drawn);
                    error_count++;
                end
                if (got.read_data != 0) reads_nonzero++;
                if (got.char_drawn) chars_drawn++;
            end
            if (m_tdata[15:9] != 0) begin
                $error("m_tdata padding: expected 0, got %h", m_tdata[15:9]);
                error_count++;
            end
        end
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        row_t rows [$];
        res_t none;
        cmd_t c;
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        quiet_tail   = 1'b0;
        stall_enable = 1'b1;
        shadow_col   = 0;
        shadow_row   = 0;
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
        none = '0;

        // Directed rows: fixed expectations where they are plain to see.
        rows.push_back('{make_cmd(FN_READ, 0, 0, 0, 0, 0), 1, res_t'{8'h00, 1'b0}});
        rows.push_back('{make_cmd(FN_READ, W-1, H-1, 0, 0, 0), 1, res_t'{8'h00, 1'b0}});
        rows.push_back('{make_cmd(FN_SET, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_SET, W-1, H-1, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_SET, 255, 255, 255, 255, 127), 1, none});
        rows.push_back('{make_cmd(FN_READ, 0, 7, 0, 0, 0), 1, res_t'{8'h01, 1'b0}});
        rows.push_back('{make_cmd(FN_READ, W-1, H-1, 0, 0, 0), 1, res_t'{8'h80, 1'b0}});
        rows.push_back('{make_cmd(FN_READ, 255, 255, 0, 0, 0), 1, res_t'{8'h00, 1'b0}});
        rows.push_back('{make_cmd(FN_CLR, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_READ, 0, 0, 0, 0, 0), 1, res_t'{8'h00, 1'b0}});
        rows.push_back('{make_cmd(FN_HLINE, 255, 9, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_VLINE, 50, 255, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_READ, 50, 8, 0, 0, 0), 1, res_t'{8'hFF, 1'b0}});
        rows.push_back('{make_cmd(FN_GLYPH, 96, 60, 0, 0, 65), 0, none});
        rows.push_back('{make_cmd(FN_GLYPH, 250, 250, 0, 0, 48), 0, none});
        rows.push_back('{make_cmd(FN_READ, 97, 56, 0, 0, 0), 0, none});
        rows.push_back('{make_cmd(FN_CURS, 95, 56, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_PUTC, 0, 0, 0, 0, 65), 1, res_t'{8'h00, 1'b1}});
        rows.push_back('{make_cmd(FN_PUTC, 0, 0, 0, 0, 127), 1, res_t'{8'h00, 1'b1}});
        rows.push_back('{make_cmd(FN_CURS, 0, 57, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_PUTC, 0, 0, 0, 0, 48), 1, res_t'{8'h00, 1'b0}});
        rows.push_back('{make_cmd(FN_READ, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_cmd(4'd15, 255, 255, 255, 255, 127), 1, none});
        rows.push_back('{make_cmd(FN_ERASE, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(FN_READ, 50, 8, 0, 0, 0), 1, res_t'{8'h00, 1'b0}});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) send_item(rows[i].cmd, rows[i].check_fixed, rows[i].fixed);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                // Let the block run completely dry once before continuing.
                s_tvalid <= 1'b0;
                drain();
            end
            if (n == N_RANDOM - 80) quiet_tail = 1'b1;
            c = random_cmd();
            send_item(c, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        drain();
        repeat (2000) @(posedge clk);

        $display("Covered %0d commands: %0d results, %0d nonzero reads, %0d characters drawn.",
                 items_sent, results_seen, reads_nonzero, chars_drawn);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/fbt_pkg.sv
hdl/fbt_ram.sv
hdl/fbt_front.sv
hdl/fbt_back.sv
hdl/page_framebuffer_text_engine.sv
hdl/fbt_checker.sv
tb/sv/tb_page_framebuffer_text_engine.sv
